// ----- rtl/bero_pkg.sv -----
// Package for the 3x3 binary erosion block.
// Holds dimension defaults, register widths, reset values and register indexes.
// No dependencies.
`default_nettype none
package bero_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 4096;
  localparam int WIN_SIZE       = 3;

  localparam int PIXEL_W = 8;

  localparam int IMG_W_W   = 11;
  localparam int IMG_H_W   = 13;
  localparam int MASK_W    = WIN_SIZE * WIN_SIZE;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;

  localparam logic [IMG_W_W-1:0] IMG_W_RST = IMG_W_W'(1024);
  localparam logic [IMG_H_W-1:0] IMG_H_RST = IMG_H_W'(1024);
  localparam logic [MASK_W-1:0]  MASK_RST  = MASK_W'(511);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_ELEMENT_MASK = 2'd2
  } cfg_idx_t;

  typedef logic [WIN_SIZE-1:0] win_col_t;

endpackage : bero_pkg
`default_nettype wire

// ----- rtl/bero_if.sv -----
// Valid/ready channel interfaces: pixel input and erosion result output.
// Depends on bero_pkg.
`default_nettype none
interface bero_pix_if
  import bero_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface : bero_pix_if

interface bero_res_if #(
  parameter int RW = 12,
  parameter int CW = 10
) ();
  logic          valid;
  logic          ready;
  logic [RW-1:0] out_row;
  logic [CW-1:0] out_col;
  logic          eroded;
  logic          frame_last;

  modport source (output valid, output out_row, output out_col, output eroded,
                  output frame_last, input ready);
  modport sink   (input valid, input out_row, input out_col, input eroded,
                  input frame_last, output ready);
endinterface : bero_res_if
`default_nettype wire

// ----- rtl/binary_erosion_3x3.sv -----
// Streaming 3x3 binary erosion: two-deep line RAM feeding a row of window cells.
// Throughput: one item per cycle while the output is not stalled. Each pixel
// passes in order through the RAM read, the window shift and the output register.
// Sync active-low reset clears position, pipeline valids and config registers
// (width 1024, height 1024, mask all ones); line RAM contents are not cleared.
// Uses bero_pkg, bero_if, bero_ram, bero_cell.
`default_nettype none
module binary_erosion_3x3
  import bero_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  bero_pix_if.sink                   in_pix,
  bero_res_if.source                 out_res,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  // configuration
  logic [IMG_W_W-1:0] img_w_r;
  logic [IMG_H_W-1:0] img_h_r;
  logic [MASK_W-1:0]  mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= IMG_W_RST;
      img_h_r <= IMG_H_RST;
      mask_r  <= MASK_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_IMAGE_WIDTH:  img_w_r <= cfg_wdata[IMG_W_W-1:0];
        CFG_IMAGE_HEIGHT: img_h_r <= cfg_wdata[IMG_H_W-1:0];
        CFG_ELEMENT_MASK: mask_r  <= cfg_wdata[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;

  always_comb begin
    if (32'(img_w_r) < 32'(WIN_SIZE)) begin
      w_eff = WW'(WIN_SIZE);
    end else if (32'(img_w_r) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(img_w_r);
    end
    if (32'(img_h_r) < 32'(WIN_SIZE)) begin
      h_eff = HW'(WIN_SIZE);
    end else if (32'(img_h_r) > 32'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(img_h_r);
    end
  end

  // pipeline handshake
  logic v1_r, v2_r, out_valid_r;
  logic emit2_r;
  logic out_take, s2_leave, s2_free, s1_leave, s1_free, in_acc;

  assign out_take = !out_valid_r || out_res.ready;
  assign s2_leave = v2_r && (out_take || !emit2_r);
  assign s2_free  = !v2_r || s2_leave;
  assign s1_leave = v1_r && s2_free;
  assign s1_free  = !v1_r || s1_leave;
  assign in_acc   = in_pix.valid && s1_free;

  assign in_pix.ready = s1_free;

  // raster position
  logic [CW-1:0] col_r, col_nxt, c_cur;
  logic [RW-1:0] row_r, row_nxt, r_cur;
  logic [RW:0]   r_tmp, r_next_full;
  logic [CW:0]   c_next_full;
  logic          emit0, last0;

  always_comb begin
    if (32'(col_r) >= 32'(w_eff)) begin
      c_cur = '0;
      r_tmp = {1'b0, row_r} + (RW+1)'(1);
    end else begin
      c_cur = col_r;
      r_tmp = {1'b0, row_r};
    end
    r_cur = (32'(r_tmp) >= 32'(h_eff)) ? '0 : r_tmp[RW-1:0];

    c_next_full = {1'b0, c_cur} + (CW+1)'(1);
    r_next_full = {1'b0, r_cur} + (RW+1)'(1);
    if (32'(c_next_full) >= 32'(w_eff)) begin
      col_nxt = '0;
      row_nxt = (32'(r_next_full) >= 32'(h_eff)) ? '0 : r_next_full[RW-1:0];
    end else begin
      col_nxt = c_next_full[CW-1:0];
      row_nxt = r_cur;
    end

    emit0 = (32'(r_cur) >= 32'(2)) && (32'(c_cur) >= 32'(2));
    last0 = (32'(r_cur) == 32'(h_eff) - 32'(1)) && (32'(c_cur) == 32'(w_eff) - 32'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // stage 1: line RAM read in flight
  logic          b1_r, emit1_r, last1_r;
  logic [CW-1:0] c1_r;
  logic [RW-1:0] r1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (s1_free) begin
      v1_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      b1_r    <= |in_pix.pixel;
      c1_r    <= c_cur;
      r1_r    <= r_cur;
      emit1_r <= emit0;
      last1_r <= last0;
    end
  end

  // bit 0: row above, bit 1: two rows above
  logic [1:0] line_rd;

  bero_ram #(
    .WIDTH (2),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_leave),
    .waddr (c1_r),
    .wdata ({line_rd[0], b1_r}),
    .re    (in_acc),
    .raddr (c_cur),
    .rdata (line_rd)
  );

  // window cells, index 0 is the left column
  win_col_t new_col;
  win_col_t cell_col [WIN_SIZE];
  logic [WIN_SIZE-1:0] hits;

  assign new_col = {b1_r, line_rd[0], line_rd[1]};

  for (genvar k = 0; k < WIN_SIZE; k++) begin : g_cell
    win_col_t mcol;
    win_col_t cin;

    for (genvar j = 0; j < WIN_SIZE; j++) begin : g_mask
      assign mcol[j] = mask_r[j*WIN_SIZE + k];
    end

    if (k == WIN_SIZE - 1) begin : g_right
      assign cin = new_col;
    end else begin : g_inner
      assign cin = cell_col[k+1];
    end

    bero_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (s1_leave),
      .col_in   (cin),
      .mask_col (mcol),
      .col_out  (cell_col[k]),
      .hit      (hits[k])
    );
  end

  // stage 2: window holds this item's neighborhood
  logic [CW-1:0] c2_r;
  logic [RW-1:0] r2_r;
  logic          last2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (s2_free) begin
      v2_r <= s1_leave;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_leave) begin
      c2_r    <= c1_r;
      r2_r    <= r1_r;
      emit2_r <= emit1_r;
      last2_r <= last1_r;
    end
  end

  // output register
  logic [RW-1:0] out_row_r;
  logic [CW-1:0] out_col_r;
  logic          eroded_r, last_r;
  logic          out_load;

  assign out_load = s2_leave && emit2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_take) begin
      out_valid_r <= out_load;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_row_r <= r2_r - RW'(1);
      out_col_r <= c2_r - CW'(1);
      eroded_r  <= &hits;
      last_r    <= last2_r;
    end
  end

  assign out_res.valid      = out_valid_r;
  assign out_res.out_row    = out_row_r;
  assign out_res.out_col    = out_col_r;
  assign out_res.eroded     = eroded_r;
  assign out_res.frame_last = last_r;

endmodule : binary_erosion_3x3
`default_nettype wire

// ----- rtl/bero_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module bero_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : bero_ram
`default_nettype wire

// ----- rtl/bero_cell.sv -----
// One window column cell: holds three vertical bits, passes them left on shift,
// and checks them against its column of the structuring element. Uses bero_pkg.
`default_nettype none
module bero_cell
  import bero_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     shift_en,
  input  wire win_col_t col_in,
  input  wire win_col_t mask_col,
  output      win_col_t col_out,
  output      logic     hit
);

  win_col_t col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else if (shift_en) begin
      col_r <= col_in;
    end
  end

  assign col_out = col_r;
  assign hit     = &(col_r | ~mask_col);

endmodule : bero_cell
`default_nettype wire
